// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. They vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lskf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lskf_pkg;

    localparam int TICK_W  = 16;
    localparam int STEP_W  = $clog2(TICK_W);
    localparam int N_LANES = 4;

    // Remainder lanes, one per modulus register.
    localparam int LANE_CHECK   = 0;
    localparam int LANE_TIMEOUT = 1;
    localparam int LANE_ALIVE   = 2;
    localparam int LANE_RETRY   = 3;

    localparam logic [7:0]        OWN_ID_RST    = 8'h26;
    localparam logic [TICK_W-1:0] CHECK_RST     = 16'd10;
    localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd200;
    localparam logic [TICK_W-1:0] ALIVE_RST     = 16'd300;
    localparam logic [TICK_W-1:0] RETRY_RST     = 16'd5;
    localparam logic [TICK_W-1:0] TICK_WRAP_RST = 16'd20000;

    typedef enum logic [2:0] {
        CFG_OWN_DEVICE_ID   = 3'd0,
        CFG_CHECK_INTERVAL  = 3'd1,
        CFG_CONNECT_TIMEOUT = 3'd2,
        CFG_ALIVE_WINDOW    = 3'd3,
        CFG_RETRY_INTERVAL  = 3'd4,
        CFG_TICK_WRAP       = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_OFFER     = 3'd1,
        ACT_REPORTACK = 3'd2,
        ACT_HEARTBEAT = 3'd3,
        ACT_RECONNECT = 3'd4,
        ACT_OTHER     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_DISCOVERING = 2'd0,
        MODE_CONNECTING  = 2'd1,
        MODE_CONNECTED   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] device_id;
        logic [7:0] session_id;
    } in_item_t;

    typedef struct packed {
        logic       send_discover;
        logic       accept_session;
        logic       send_heartbeat;
        logic       clear_pending_acks;
        logic       drop_report_retry;
        logic       retry_check_due;
        logic [1:0] link_state;
        logic [7:0] current_session;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic item_tick;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/lskf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lskf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire lskf_pkg::dp_status_t status,
    output lskf_pkg::ctrl_cmd_t      cmd
);
    import lskf_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_tick)
                    begin
                        state_next    = ST_CALC;
                        step_cnt_next = '0;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CALC:
            begin
                // One dividend bit enters all remainder lanes per cycle.
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg + STEP_W'(1);
                if (step_cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.commit | (out_valid_reg & out_stall);
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/lskf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lskf_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lskf_pkg::in_item_t   in_item,
    output lskf_pkg::out_item_t       out_item,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire lskf_pkg::ctrl_cmd_t  cmd,
    output lskf_pkg::dp_status_t      status
);
    import lskf_pkg::*;

    logic [7:0]        own_device_id_reg;
    logic [TICK_W-1:0] check_interval_reg;
    logic [TICK_W-1:0] connect_timeout_reg;
    logic [TICK_W-1:0] alive_window_reg;
    logic [TICK_W-1:0] retry_interval_reg;
    logic [TICK_W-1:0] tick_wrap_reg;

    mode_t             mode_reg, mode_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [7:0]        heartbeat_count_reg, heartbeat_count_next;
    logic [7:0]        stored_session_reg, stored_session_next;

    in_item_t          item_reg;
    logic [TICK_W-1:0] dividend_reg;
    logic [TICK_W-1:0] rem_reg  [N_LANES];
    logic [TICK_W-1:0] rem_next [N_LANES];
    logic [TICK_W-1:0] modulus  [N_LANES];
    logic [N_LANES-1:0] hit;
    out_item_t         out_item_reg, out_item_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_device_id_reg   <= OWN_ID_RST;
            check_interval_reg  <= CHECK_RST;
            connect_timeout_reg <= TIMEOUT_RST;
            alive_window_reg    <= ALIVE_RST;
            retry_interval_reg  <= RETRY_RST;
            tick_wrap_reg       <= TICK_WRAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_DEVICE_ID:   own_device_id_reg   <= cfg_data[7:0];
                CFG_CHECK_INTERVAL:  check_interval_reg  <= cfg_data;
                CFG_CONNECT_TIMEOUT: connect_timeout_reg <= cfg_data;
                CFG_ALIVE_WINDOW:    alive_window_reg    <= cfg_data;
                CFG_RETRY_INTERVAL:  retry_interval_reg  <= cfg_data;
                CFG_TICK_WRAP:       tick_wrap_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign modulus[LANE_CHECK]   = check_interval_reg;
    assign modulus[LANE_TIMEOUT] = connect_timeout_reg;
    assign modulus[LANE_ALIVE]   = alive_window_reg;
    assign modulus[LANE_RETRY]   = retry_interval_reg;

    assign tick_count_next = (tick_count_reg >= tick_wrap_reg) ? '0
                                                               : tick_count_reg + TICK_W'(1);

    // Restoring remainder, one bit per step; a zero modulus never hits.
    always_comb
    begin
        logic [TICK_W:0] trial;
        logic [TICK_W:0] diff;
        for (int k = 0; k < N_LANES; k++)
        begin
            trial = {rem_reg[k], dividend_reg[TICK_W-1]};
            diff  = trial - {1'b0, modulus[k]};
            if (trial >= {1'b0, modulus[k]})
            begin
                rem_next[k] = diff[TICK_W-1:0];
            end
            else
            begin
                rem_next[k] = trial[TICK_W-1:0];
            end
            hit[k] = (modulus[k] != '0) && (rem_reg[k] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg     <= in_item;
            dividend_reg <= tick_count_next;
            for (int k = 0; k < N_LANES; k++)
            begin
                rem_reg[k] <= '0;
            end
        end
        else if (cmd.step)
        begin
            dividend_reg <= {dividend_reg[TICK_W-2:0], 1'b0};
            for (int k = 0; k < N_LANES; k++)
            begin
                rem_reg[k] <= rem_next[k];
            end
        end
        if (cmd.commit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_comb
    begin
        mode_next            = mode_reg;
        heartbeat_count_next = heartbeat_count_reg;
        stored_session_next  = stored_session_reg;
        out_item_next        = '0;
        unique case (item_reg.action)
            ACT_TICK:
            begin
                if (hit[LANE_CHECK])
                begin
                    unique case (mode_reg)
                        MODE_DISCOVERING:
                        begin
                            out_item_next.send_discover = 1'b1;
                        end
                        MODE_CONNECTING:
                        begin
                            if (hit[LANE_TIMEOUT])
                            begin
                                out_item_next.clear_pending_acks = 1'b1;
                                mode_next = MODE_DISCOVERING;
                            end
                        end
                        MODE_CONNECTED:
                        begin
                            if (hit[LANE_ALIVE])
                            begin
                                if (heartbeat_count_reg == '0)
                                begin
                                    out_item_next.clear_pending_acks = 1'b1;
                                    mode_next = MODE_DISCOVERING;
                                end
                                else
                                begin
                                    heartbeat_count_next = '0;
                                end
                            end
                            out_item_next.send_heartbeat = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                out_item_next.retry_check_due = hit[LANE_RETRY];
            end
            ACT_OFFER:
            begin
                if (mode_reg == MODE_DISCOVERING && item_reg.device_id == own_device_id_reg)
                begin
                    stored_session_next          = item_reg.session_id;
                    mode_next                    = MODE_CONNECTING;
                    out_item_next.accept_session = 1'b1;
                end
            end
            ACT_REPORTACK:
            begin
                out_item_next.drop_report_retry = 1'b1;
                mode_next = MODE_CONNECTED;
            end
            ACT_HEARTBEAT:
            begin
                heartbeat_count_next = heartbeat_count_reg + 8'd1;
            end
            ACT_RECONNECT:
            begin
                if (item_reg.session_id == stored_session_reg)
                begin
                    out_item_next.clear_pending_acks = 1'b1;
                    mode_next = MODE_DISCOVERING;
                end
            end
            default:
            begin
            end
        endcase
        out_item_next.link_state      = mode_next;
        out_item_next.current_session = stored_session_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_DISCOVERING;
            tick_count_reg      <= '0;
            heartbeat_count_reg <= '0;
            stored_session_reg  <= '0;
        end
        else
        begin
            if (cmd.accept && in_item.action == ACT_TICK)
            begin
                tick_count_reg <= tick_count_next;
            end
            if (cmd.commit)
            begin
                mode_reg            <= mode_next;
                heartbeat_count_reg <= heartbeat_count_next;
                stored_session_reg  <= stored_session_next;
            end
        end
    end

    assign status.in_tick   = (in_item.action == ACT_TICK);
    assign status.item_tick = (item_reg.action == ACT_TICK);
    assign out_item         = out_item_reg;

endmodule

`default_nettype wire

// ===== sv/link_session_keepalive_fsm.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_item   (action, device_id, session_id)
// out       out_valid / out_stall  out_item  (request flags, link_state, session)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick item runs the bit-serial remainder lanes between acceptance and result,
// one bit of the tick count per cycle for all four moduli at once. Any other item
// skips the remainder lanes. One item is in work at a time;
// a new item is taken while the previous result still waits at the output.
// Reset is asynchronous and restores the register defaults; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module link_session_keepalive_fsm (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire lskf_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output lskf_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import lskf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lskf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lskf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    // An accepted item blocks the input until its result is committed.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // A result is only written into a free output register.
    `ASSERT_SAME(a_commit_free, clk, rst_n, cmd.commit, !out_valid || !out_stall)
    // Items other than ticks never flag a retry check.
    `ASSERT_NEXT(a_retry_tick_only, clk, rst_n, cmd.commit && !status.item_tick,
                 !out_item.retry_check_due)

endmodule

`default_nettype wire

// ===== test/link_session_keepalive_fsm_test.sv =====
`timescale 1ns / 1ps

module link_session_keepalive_fsm_test;
    import lskf_pkg::*;

    // Register indexes and actions that the block decodes as no-ops.
    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
    localparam logic [2:0] ACT_SPARE_LO  = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_PERCENT  = 11;

    class session_scoreboard;
        logic [7:0]  own_id;
        logic [15:0] check_iv;
        logic [15:0] conn_to;
        logic [15:0] alive_win;
        logic [15:0] retry_iv;
        logic [15:0] wrap_at;
        mode_t       mode;
        logic [15:0] ticks;
        logic [7:0]  beats;
        logic [7:0]  session;
        out_item_t   expected_q[$];
        int          errors;
        int          events_seen;
        int          results_seen;

        function new();
            own_id       = OWN_ID_RST;
            check_iv     = CHECK_RST;
            conn_to      = TIMEOUT_RST;
            alive_win    = ALIVE_RST;
            retry_iv     = RETRY_RST;
            wrap_at      = TICK_WRAP_RST;
            mode         = MODE_DISCOVERING;
            ticks        = '0;
            beats        = '0;
            session      = '0;
            errors       = 0;
            events_seen  = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_OWN_DEVICE_ID:   own_id = data[7:0];
                CFG_CHECK_INTERVAL:  check_iv = data;
                CFG_CONNECT_TIMEOUT: conn_to = data;
                CFG_ALIVE_WINDOW:    alive_win = data;
                CFG_RETRY_INTERVAL:  retry_iv = data;
                CFG_TICK_WRAP:       wrap_at = data;
                default: ;
            endcase
        endfunction

        // A modulus of zero never matches.
        function bit lands(logic [15:0] t, logic [15:0] m);
            return (m != 16'd0) && ((t % m) == 16'd0);
        endfunction

        function void note_item(in_item_t it);
            out_item_t r;
            r = '0;
            case (it.action)
                ACT_TICK:
                begin
                    if (ticks >= wrap_at)
                        ticks = '0;
                    else
                        ticks = ticks + 16'd1;
                    if (lands(ticks, check_iv))
                    begin
                        case (mode)
                            MODE_DISCOVERING: r.send_discover = 1'b1;
                            MODE_CONNECTING:
                            begin
                                if (lands(ticks, conn_to))
                                begin
                                    r.clear_pending_acks = 1'b1;
                                    mode = MODE_DISCOVERING;
                                end
                            end
                            MODE_CONNECTED:
                            begin
                                if (lands(ticks, alive_win))
                                begin
                                    if (beats == 8'd0)
                                    begin
                                        r.clear_pending_acks = 1'b1;
                                        mode = MODE_DISCOVERING;
                                    end
                                    else
                                        beats = '0;
                                end
                                r.send_heartbeat = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    r.retry_check_due = lands(ticks, retry_iv);
                end
                ACT_OFFER:
                begin
                    if (mode == MODE_DISCOVERING && it.device_id == own_id)
                    begin
                        session = it.session_id;
                        mode = MODE_CONNECTING;
                        r.accept_session = 1'b1;
                    end
                end
                ACT_REPORTACK:
                begin
                    r.drop_report_retry = 1'b1;
                    mode = MODE_CONNECTED;
                end
                ACT_HEARTBEAT: beats = beats + 8'd1;
                ACT_RECONNECT:
                begin
                    if (it.session_id == session)
                    begin
                        r.clear_pending_acks = 1'b1;
                        mode = MODE_DISCOVERING;
                    end
                end
                default: ;
            endcase
            r.link_state = mode;
            r.current_session = session;
            expected_q.push_back(r);
            events_seen++;
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("result arrived with no event outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            compare("send_discover", want.send_discover, got.send_discover);
            compare("accept_session", want.accept_session, got.accept_session);
            compare("send_heartbeat", want.send_heartbeat, got.send_heartbeat);
            compare("clear_pending_acks", want.clear_pending_acks, got.clear_pending_acks);
            compare("drop_report_retry", want.drop_report_retry, got.drop_report_retry);
            compare("retry_check_due", want.retry_check_due, got.retry_check_due);
            compare("link_state", want.link_state, got.link_state);
            compare("current_session", want.current_session, got.current_session);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    session_scoreboard sb;
    bit quiet;
    bit hold_go;
    int holds_done;
    int settings_run;

    link_session_keepalive_fsm u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
        end
    end

    // Receiver: random stalls, and on request one long hold-off so the block backs up.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_go = 1'b0;
                holds_done++;
            end
            out_stall = !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    initial
    begin
        #5_000_000;
        $display("link_session_keepalive_fsm_test: FAIL");
        $finish;
    end

    function automatic in_item_t make_event(logic [2:0] act, logic [7:0] dev, logic [7:0] sess);
        in_item_t it;
        it.action = act;
        it.device_id = dev;
        it.session_id = sess;
        return it;
    endfunction

    // Mostly a sensible link conversation driven off the predicted state, with some noise.
    function automatic in_item_t next_event();
        in_item_t it;
        int r;
        it.device_id = 8'($urandom_range(0, 255));
        it.session_id = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 45)
            it.action = ACT_TICK;
        else if (r < 60)
            it.action = ACT_HEARTBEAT;
        else if (r < 74)
        begin
            it.action = ACT_OFFER;
            if ($urandom_range(0, 9) < 8)
                it.device_id = sb.own_id;
        end
        else if (r < 83)
            it.action = ACT_REPORTACK;
        else if (r < 92)
        begin
            it.action = ACT_RECONNECT;
            if ($urandom_range(0, 9) < 7)
                it.session_id = sb.session;
        end
        else if (r < 95)
            it.action = ACT_OTHER;
        else if (r < 97)
            it.action = ACT_SPARE_LO;
        else
            it.action = ACT_SPARE_HI;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer_item(input in_item_t it);
        if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic run_events(input int count);
        repeat (count) offer_item(next_event());
        in_valid = 1'b0;
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic pick_modulus(output logic [15:0] v, input int hi);
        if ($urandom_range(0, 99) < 8)
            v = 16'd0;
        else
            v = 16'($urandom_range(1, hi));
    endtask

    task automatic program_settings(input int k);
        logic [15:0] own_v;
        logic [15:0] chk_v;
        logic [15:0] to_v;
        logic [15:0] alive_v;
        logic [15:0] retry_v;
        logic [15:0] wrap_v;
        case (k)
            1:
            begin
                own_v = 16'hFFFF;
                chk_v = 16'd1;
                to_v = 16'd1;
                alive_v = 16'd1;
                retry_v = 16'd1;
                wrap_v = 16'hFFFF;
            end
            2:
            begin
                own_v = 16'h0000;
                chk_v = 16'hFFFF;
                to_v = 16'hFFFF;
                alive_v = 16'hFFFF;
                retry_v = 16'hFFFF;
                wrap_v = 16'd1;
            end
            3:
            begin
                own_v = 16'($urandom_range(0, 16'hFFFF));
                chk_v = 16'd0;
                to_v = 16'd0;
                alive_v = 16'd0;
                retry_v = 16'd0;
                wrap_v = 16'd0;
            end
            default:
            begin
                // Small moduli so the periodic checks fire often; upper id bits are junk.
                own_v = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
                pick_modulus(chk_v, 6);
                pick_modulus(to_v, 16);
                pick_modulus(alive_v, 24);
                pick_modulus(retry_v, 8);
                wrap_v = 16'($urandom_range(2, 80));
            end
        endcase
        write_reg(CFG_OWN_DEVICE_ID, own_v);
        write_reg(CFG_CHECK_INTERVAL, chk_v);
        write_reg(CFG_CONNECT_TIMEOUT, to_v);
        write_reg(CFG_ALIVE_WINDOW, alive_v);
        write_reg(CFG_RETRY_INTERVAL, retry_v);
        write_reg(CFG_TICK_WRAP, wrap_v);
        if (k == 3)
        begin
            write_reg(CFG_UNUSED_LO, 16'hFFFF);
            write_reg(CFG_UNUSED_HI, 16'hA5A5);
        end
        settings_run++;
    endtask

    task automatic directed_events();
        offer_item(make_event(ACT_TICK, 8'h00, 8'h00));
        offer_item(make_event(ACT_OFFER, 8'h00, 8'hAA));
        offer_item(make_event(ACT_OFFER, sb.own_id, 8'hFF));
        offer_item(make_event(ACT_OFFER, sb.own_id, 8'h11));
        offer_item(make_event(ACT_RECONNECT, 8'hFF, 8'h00));
        offer_item(make_event(ACT_RECONNECT, 8'h00, 8'hFF));
        offer_item(make_event(ACT_REPORTACK, 8'hFF, 8'hFF));
        offer_item(make_event(ACT_HEARTBEAT, 8'h55, 8'hAA));
        offer_item(make_event(ACT_OTHER, 8'hFF, 8'hFF));
        offer_item(make_event(ACT_SPARE_LO, 8'hFF, 8'h00));
        offer_item(make_event(ACT_SPARE_HI, 8'h00, 8'hFF));
        offer_item(make_event(ACT_OFFER, 8'hFF, 8'h00));
        offer_item(make_event(ACT_RECONNECT, 8'h00, 8'hFF));
        offer_item(make_event(ACT_OFFER, sb.own_id, 8'h00));
        offer_item(make_event(ACT_REPORTACK, 8'h00, 8'h00));
        repeat (9) offer_item(make_event(ACT_TICK, 8'h00, 8'h00));
        in_valid = 1'b0;
    endtask

    // Drive the heartbeat count to zero, then 256 heartbeats must wrap it back to
    // zero so the next alive judgment declares the host lost.
    task automatic heartbeat_wrap_run();
        write_reg(CFG_CHECK_INTERVAL, 16'd1);
        write_reg(CFG_ALIVE_WINDOW, 16'd1);
        repeat (2)
        begin
            offer_item(make_event(ACT_REPORTACK, 8'h00, 8'h00));
            offer_item(make_event(ACT_TICK, 8'h00, 8'h00));
        end
        settle();
        write_reg(CFG_ALIVE_WINDOW, 16'd0);
        offer_item(make_event(ACT_REPORTACK, 8'h00, 8'h00));
        repeat (256) offer_item(make_event(ACT_HEARTBEAT, 8'($urandom), 8'($urandom)));
        settle();
        write_reg(CFG_ALIVE_WINDOW, 16'd1);
        offer_item(make_event(ACT_REPORTACK, 8'h00, 8'h00));
        offer_item(make_event(ACT_TICK, 8'h00, 8'h00));
        settle();
        settings_run++;
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OWN_DEVICE_ID;
        cfg_data = '0;
        quiet = 1'b0;
        hold_go = 1'b0;
        holds_done = 0;
        settings_run = 1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_events();
        run_events(100);
        settle();

        for (int k = 1; k <= 11; k++)
        begin
            program_settings(k);
            if (k == 5)
                hold_go = 1'b1;
            quiet = (k == 7);
            run_events(110);
            settle();
            quiet = 1'b0;
            if (k == 3)
                heartbeat_wrap_run();
        end

        $display("Covered %0d link events with %0d results checked over %0d register settings,",
                 sb.events_seen, sb.results_seen, settings_run);
        $display("including zero and full-range moduli, a heartbeat wrap and %0d output hold-off(s).",
                 holds_done);
        if (sb.errors == 0)
            $display("link_session_keepalive_fsm_test: PASS");
        else
            $display("link_session_keepalive_fsm_test: FAIL");
        $finish;
    end

endmodule

// ===== link_session_keepalive_fsm.f =====
+incdir+sv
sv/lskf_pkg.sv
sv/lskf_ctrl.sv
sv/lskf_datapath.sv
sv/link_session_keepalive_fsm.sv
test/link_session_keepalive_fsm_test.sv
